// File: sv/sound_card_port_and_bank_unit_assert.svh
// Assertion macros for the sound card port and bank unit.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef SOUND_CARD_PORT_AND_BANK_UNIT_ASSERT_SVH
`define SOUND_CARD_PORT_AND_BANK_UNIT_ASSERT_SVH

// same-cycle implication
`define SCPB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/scpb_pkg.sv
// Package of the sound card port and bank unit: widths, codes, command type.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package scpb_pkg;

    localparam int BANK_BYTES = 16384;
    localparam int COUNT_BITS = 24;

    localparam int ADDR_W   = 16;
    localparam int OFFSET_W = 19;
    localparam int SUM_W    = 32;
    localparam int VOL_W    = 6;
    localparam int LEVEL_W  = 4;
    localparam int NUM_CH   = 4;
    localparam int CH_W     = 2;

    // level = sum * volume / (count * LEVEL_DIV_UNIT + 1)
    localparam int LEVEL_DIV_UNIT  = 16'h100 * 16'h40 / 16;
    localparam int LEVEL_DIV_SHIFT = $clog2(LEVEL_DIV_UNIT);
    localparam int NUM_W = SUM_W + VOL_W;
    localparam int DEN_W = COUNT_BITS + LEVEL_DIV_SHIFT + 1;
    localparam int DIV_W = (NUM_W > DEN_W + LEVEL_W) ? NUM_W : DEN_W + LEVEL_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // request codes
    localparam logic [2:0] REQ_HOST_WR = 3'd0;
    localparam logic [2:0] REQ_HOST_RD = 3'd1;
    localparam logic [2:0] REQ_CPU_WR  = 3'd2;
    localparam logic [2:0] REQ_CPU_RD  = 3'd3;
    localparam logic [2:0] REQ_MEM_RD  = 3'd4;
    localparam logic [2:0] REQ_MEM_WR  = 3'd5;
    localparam logic [2:0] REQ_FLUSH   = 3'd6;

    localparam logic [7:0]  HOST_PORT       = 8'hBB;
    localparam logic [7:0]  HOST_STATUS_OR  = 8'h7E;
    localparam logic [15:0] SAMPLE_WIN_MASK = 16'hE000;
    localparam logic [15:0] SAMPLE_WIN_BASE = 16'h6000;

    // card cpu port codes
    localparam logic [3:0] PORT_PAGE      = 4'h0;
    localparam logic [3:0] PORT_CMD       = 4'h1;
    localparam logic [3:0] PORT_DATA_IN   = 4'h2;
    localparam logic [3:0] PORT_DATA_OUT  = 4'h3;
    localparam logic [3:0] PORT_STATUS    = 4'h4;
    localparam logic [3:0] PORT_CLR_CMD   = 4'h5;
    localparam logic [3:0] PORT_VOL0      = 4'h6;
    localparam logic [3:0] PORT_VOL1      = 4'h7;
    localparam logic [3:0] PORT_VOL2      = 4'h8;
    localparam logic [3:0] PORT_VOL3      = 4'h9;
    localparam logic [3:0] PORT_PAGE_STAT = 4'hA;
    localparam logic [3:0] PORT_VOL_STAT  = 4'hB;

    localparam int STAT_CMD_BIT  = 0;
    localparam int STAT_DATA_BIT = 7;

    localparam logic [1:0] REGION_ROM     = 2'd0;
    localparam logic [1:0] REGION_RAM     = 2'd1;
    localparam logic [1:0] REGION_DISCARD = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOST_WR_CMD,
        OP_HOST_WR_DATA,
        OP_HOST_RD_STATUS,
        OP_HOST_RD_DATA,
        OP_CPU_WR,
        OP_CPU_RD,
        OP_MEM_RD,
        OP_MEM_WR,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [3:0]        port;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic              capture;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: sv/sound_card_port_and_bank_unit.sv
// Top level of the sound card port and bank unit.
// Depends on scpb_pkg, scpb_front, scpb_queue, scpb_back and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "sound_card_port_and_bank_unit_assert.svh"

// Usage:
//   Requests enter on start while busy is low; req_type selects host port
//   access, card cpu port access, memory access or a level flush.
//   Results leave on done, one cycle each, with last on the final one of
//   an item; the receiver cannot hold them off.
//   The front end decodes a request into a command and pushes it into a
//   two-entry queue; busy is high while that queue is full.
//   The back end pops one command a cycle while no flush holds it, and executes it.
// Flow:
//   Port and memory items: result registered in the queue entry and then in
//   the output registers; one item per cycle sustained while no flush holds
//   the back end. Flush: four results, one per channel; each channel takes
//   one multiply state and five steps of the compare-subtract divider, and
//   later items wait in the queue while a flush holds the back end.
// Reset: rst_n clears all latches, status, page, volumes, samples, sums and
//   counts, and empties the queue.

module sound_card_port_and_bank_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  port,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  mem_byte,
    output logic             done,
    output logic [7:0]       read_data,
    output logic [1:0]       mem_region,
    output logic [18:0]      mem_offset,
    output logic             dac_valid,
    output logic [1:0]       channel,
    output logic [7:0]       sample,
    output logic [5:0]       volume,
    output logic [3:0]       level,
    output logic             last
);

    scpb_pkg::cmd_t    front_cmd;
    scpb_pkg::cmd_t    head_cmd;
    scpb_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    // an item is taken whenever the queue has room
    assign busy = q_stat.full;
    assign push = start && !busy;

    scpb_front u_front (
        .req_type   (req_type),
        .port       (port),
        .address    (address),
        .write_data (write_data),
        .mem_byte   (mem_byte),
        .cmd        (front_cmd)
    );

    scpb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .stat     (q_stat)
    );

    scpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (head_cmd),
        .q_stat     (q_stat),
        .pop        (pop),
        .done       (done),
        .read_data  (read_data),
        .mem_region (mem_region),
        .mem_offset (mem_offset),
        .dac_valid  (dac_valid),
        .channel    (channel),
        .sample     (sample),
        .volume     (volume),
        .level      (level),
        .last       (last)
    );

    // an accepted item is visible to the back end on the next cycle
    `SCPB_ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "accepted item missing from queue")
    // the back end never pops an empty queue
    `SCPB_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
    // only the first three flush results lack last
    `SCPB_ASSERT_NOW(a_last_ch, done && !last, channel != 2'd3, "flush ended without last")
    // captured samples come only from reads, which never go to discard
    `SCPB_ASSERT_NOW(a_dac_region, done && dac_valid, mem_region != scpb_pkg::REGION_DISCARD,
        "sample captured on discarded access")

endmodule

`default_nettype wire

// File: sv/scpb_front.sv
// Front end: classifies a request into a command for the execution side.
// Depends on scpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpb_front (
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  port,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic [7:0]  mem_byte,
    output scpb_pkg::cmd_t   cmd
);

    logic host_port;
    logic in_window;

    assign host_port = (port == scpb_pkg::HOST_PORT);
    assign in_window = ((address & scpb_pkg::SAMPLE_WIN_MASK) == scpb_pkg::SAMPLE_WIN_BASE);

    always_comb
    begin
        cmd.op      = scpb_pkg::OP_NONE;
        cmd.port    = port[3:0];
        cmd.address = address;
        cmd.data    = write_data;
        cmd.capture = 1'b0;
        case (req_type)
            scpb_pkg::REQ_HOST_WR:
                cmd.op = host_port ? scpb_pkg::OP_HOST_WR_CMD : scpb_pkg::OP_HOST_WR_DATA;
            scpb_pkg::REQ_HOST_RD:
                cmd.op = host_port ? scpb_pkg::OP_HOST_RD_STATUS : scpb_pkg::OP_HOST_RD_DATA;
            scpb_pkg::REQ_CPU_WR:
                cmd.op = scpb_pkg::OP_CPU_WR;
            scpb_pkg::REQ_CPU_RD:
                cmd.op = scpb_pkg::OP_CPU_RD;
            scpb_pkg::REQ_MEM_RD:
            begin
                cmd.op      = scpb_pkg::OP_MEM_RD;
                cmd.data    = mem_byte;
                cmd.capture = in_window;
            end
            scpb_pkg::REQ_MEM_WR:
                cmd.op = scpb_pkg::OP_MEM_WR;
            scpb_pkg::REQ_FLUSH:
                cmd.op = scpb_pkg::OP_FLUSH;
            default:
                cmd.op = scpb_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/scpb_queue.sv
// Short command queue between the front end and the execution side.
// Depends on scpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire scpb_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output scpb_pkg::cmd_t     head,
    output scpb_pkg::q_stat_t  stat
);

    scpb_pkg::cmd_t                     entry_reg [scpb_pkg::Q_DEPTH];
    logic [scpb_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [scpb_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [scpb_pkg::Q_CNT_W-1:0]       count_reg, count_next;

    localparam logic [scpb_pkg::Q_PTR_W-1:0] LAST_PTR = scpb_pkg::Q_PTR_W'(scpb_pkg::Q_DEPTH - 1);
    localparam logic [scpb_pkg::Q_CNT_W-1:0] FULL_CNT = scpb_pkg::Q_CNT_W'(scpb_pkg::Q_DEPTH);

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/scpb_back.sv
// Execution side: port registers, bank mapping, sample capture and level divider.
// Depends on scpb_pkg; takes commands from scpb_queue.
`timescale 1ns / 1ps
`default_nettype none

module scpb_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire scpb_pkg::cmd_t                    cmd,
    input  wire scpb_pkg::q_stat_t                 q_stat,
    output logic                                   pop,
    output logic                                   done,
    output logic [7:0]                             read_data,
    output logic [1:0]                             mem_region,
    output logic [scpb_pkg::OFFSET_W-1:0]          mem_offset,
    output logic                                   dac_valid,
    output logic [scpb_pkg::CH_W-1:0]              channel,
    output logic [7:0]                             sample,
    output logic [scpb_pkg::VOL_W-1:0]             volume,
    output logic [scpb_pkg::LEVEL_W-1:0]           level,
    output logic                                   last
);

    localparam int CALC_W = 32;
    localparam int STEP_W = 3;
    localparam logic [15:0] BANK_MASK = 16'(scpb_pkg::BANK_BYTES - 1);
    localparam logic [CALC_W-1:0] BANK = CALC_W'(scpb_pkg::BANK_BYTES);
    localparam logic [CALC_W-1:0] PAGE_SPAN = CALC_W'(2 * scpb_pkg::BANK_BYTES);
    localparam logic [scpb_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(scpb_pkg::LEVEL_W);
    localparam logic [scpb_pkg::CH_W-1:0] LAST_CH = scpb_pkg::CH_W'(scpb_pkg::NUM_CH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] cmd_latch_reg, cmd_latch_next;
    logic [7:0] h2c_reg, h2c_next;
    logic [7:0] c2h_reg, c2h_next;
    logic [7:0] status_reg, status_next;
    logic [3:0] page_reg, page_next;
    logic [scpb_pkg::VOL_W-1:0]      vol_reg    [scpb_pkg::NUM_CH];
    logic [scpb_pkg::VOL_W-1:0]      vol_next   [scpb_pkg::NUM_CH];
    logic [7:0]                      smp_reg    [scpb_pkg::NUM_CH];
    logic [7:0]                      smp_next   [scpb_pkg::NUM_CH];
    logic [scpb_pkg::SUM_W-1:0]      sum_reg    [scpb_pkg::NUM_CH];
    logic [scpb_pkg::SUM_W-1:0]      sum_next   [scpb_pkg::NUM_CH];
    logic [scpb_pkg::COUNT_BITS-1:0] count_reg  [scpb_pkg::NUM_CH];
    logic [scpb_pkg::COUNT_BITS-1:0] count_next [scpb_pkg::NUM_CH];

    logic [scpb_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic [scpb_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [scpb_pkg::DIV_W-1:0]   dsh_reg, dsh_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [scpb_pkg::LEVEL_W-1:0] q_reg, q_next;
    logic                         sat_reg, sat_next;

    logic                                done_next;
    logic [7:0]                          rdata_next;
    logic [1:0]                          region_next;
    logic [scpb_pkg::OFFSET_W-1:0]       offset_next;
    logic                                dac_next;
    logic [scpb_pkg::CH_W-1:0]           chan_next;
    logic [7:0]                          sample_next;
    logic [scpb_pkg::VOL_W-1:0]          volume_next;
    logic [scpb_pkg::LEVEL_W-1:0]        level_next;
    logic                                last_next;

    // shared read port of the per-channel registers
    logic [scpb_pkg::CH_W-1:0]       ch_sel;
    logic [scpb_pkg::VOL_W-1:0]      vol_sel;
    logic [scpb_pkg::SUM_W-1:0]      sum_sel;
    logic [scpb_pkg::COUNT_BITS-1:0] count_sel;
    logic [7:0]                      smp_sel;
    logic [scpb_pkg::SUM_W:0]        sum_add;
    logic [scpb_pkg::NUM_W-1:0]      prod;
    logic [scpb_pkg::DEN_W-1:0]      den;
    logic                            cmp;
    logic [scpb_pkg::DIV_W-1:0]      diff;

    // bank mapping
    logic [1:0]        quarter;
    logic [CALC_W-1:0] off_base;
    logic [CALC_W-1:0] off_hi;
    logic [CALC_W-1:0] ram_base;
    logic [3:0]        page_m1;
    logic              is_write;
    logic [1:0]        map_region;
    logic [CALC_W-1:0] map_offset;

    assign ch_sel    = (state_reg == S_IDLE) ? cmd.address[9:8] : ch_reg;
    assign vol_sel   = vol_reg[ch_sel];
    assign sum_sel   = sum_reg[ch_sel];
    assign count_sel = count_reg[ch_sel];
    assign smp_sel   = smp_reg[ch_sel];
    assign sum_add   = {1'b0, sum_sel} + (scpb_pkg::SUM_W + 1)'(cmd.data);
    assign prod      = scpb_pkg::NUM_W'(sum_sel) * scpb_pkg::NUM_W'(vol_sel);
    assign den       = (scpb_pkg::DEN_W'(count_sel) << scpb_pkg::LEVEL_DIV_SHIFT)
                       + scpb_pkg::DEN_W'(1);
    assign cmp       = (rem_reg >= dsh_reg);
    assign diff      = rem_reg - dsh_reg;

    assign quarter  = cmd.address[15:14];
    assign off_base = CALC_W'(cmd.address & BANK_MASK);
    assign off_hi   = (quarter == 2'd3) ? BANK : '0;
    assign page_m1  = page_reg - 4'd1;
    assign ram_base = CALC_W'(page_m1) * PAGE_SPAN;
    assign is_write = (cmd.op == scpb_pkg::OP_MEM_WR);

    always_comb
    begin
        if (quarter == 2'd1)
        begin
            map_region = scpb_pkg::REGION_RAM;
            map_offset = BANK + off_base;
        end
        else if (quarter == 2'd0 || page_reg == 4'd0)
        begin
            if (is_write)
            begin
                map_region = scpb_pkg::REGION_DISCARD;
                map_offset = '0;
            end
            else
            begin
                map_region = scpb_pkg::REGION_ROM;
                map_offset = off_hi + off_base;
            end
        end
        else
        begin
            map_region = scpb_pkg::REGION_RAM;
            map_offset = ram_base + off_hi + off_base;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_latch_next = cmd_latch_reg;
        h2c_next       = h2c_reg;
        c2h_next       = c2h_reg;
        status_next    = status_reg;
        page_next      = page_reg;
        vol_next       = vol_reg;
        smp_next       = smp_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        ch_next        = ch_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        step_next      = step_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;

        pop         = 1'b0;
        done_next   = 1'b0;
        rdata_next  = '0;
        region_next = '0;
        offset_next = '0;
        dac_next    = 1'b0;
        chan_next   = '0;
        sample_next = '0;
        volume_next = '0;
        level_next  = '0;
        last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop       = 1'b1;
                    done_next = 1'b1;
                    last_next = 1'b1;
                    case (cmd.op)
                        scpb_pkg::OP_HOST_WR_CMD:
                        begin
                            cmd_latch_next = cmd.data;
                            status_next[scpb_pkg::STAT_CMD_BIT] = 1'b1;
                        end
                        scpb_pkg::OP_HOST_WR_DATA:
                        begin
                            h2c_next = cmd.data;
                            status_next[scpb_pkg::STAT_DATA_BIT] = 1'b1;
                        end
                        scpb_pkg::OP_HOST_RD_STATUS:
                            rdata_next = status_reg | scpb_pkg::HOST_STATUS_OR;
                        scpb_pkg::OP_HOST_RD_DATA:
                        begin
                            status_next[scpb_pkg::STAT_DATA_BIT] = 1'b0;
                            rdata_next = c2h_reg;
                        end
                        scpb_pkg::OP_CPU_WR:
                        begin
                            case (cmd.port)
                                scpb_pkg::PORT_PAGE:
                                    page_next = cmd.data[3:0];
                                scpb_pkg::PORT_DATA_IN:
                                    status_next[scpb_pkg::STAT_DATA_BIT] = 1'b0;
                                scpb_pkg::PORT_DATA_OUT:
                                begin
                                    status_next[scpb_pkg::STAT_DATA_BIT] = 1'b1;
                                    c2h_next = cmd.data;
                                end
                                scpb_pkg::PORT_CLR_CMD:
                                    status_next[scpb_pkg::STAT_CMD_BIT] = 1'b0;
                                scpb_pkg::PORT_VOL0, scpb_pkg::PORT_VOL1,
                                scpb_pkg::PORT_VOL2, scpb_pkg::PORT_VOL3:
                                begin
                                    for (int k = 0; k < scpb_pkg::NUM_CH; k++)
                                    begin
                                        if (cmd.port == scpb_pkg::PORT_VOL0 + 4'(k))
                                        begin
                                            vol_next[k] = cmd.data[scpb_pkg::VOL_W-1:0];
                                        end
                                    end
                                end
                                scpb_pkg::PORT_PAGE_STAT:
                                    status_next[scpb_pkg::STAT_DATA_BIT] = page_reg[0];
                                scpb_pkg::PORT_VOL_STAT:
                                    status_next[scpb_pkg::STAT_CMD_BIT] = vol_reg[0][5];
                                default:
                                    status_next = status_reg;
                            endcase
                        end
                        scpb_pkg::OP_CPU_RD:
                        begin
                            rdata_next = 8'hFF;
                            case (cmd.port)
                                scpb_pkg::PORT_CMD:
                                    rdata_next = cmd_latch_reg;
                                scpb_pkg::PORT_DATA_IN:
                                begin
                                    status_next[scpb_pkg::STAT_DATA_BIT] = 1'b0;
                                    rdata_next = h2c_reg;
                                end
                                scpb_pkg::PORT_DATA_OUT:
                                begin
                                    status_next[scpb_pkg::STAT_DATA_BIT] = 1'b1;
                                    c2h_next = 8'hFF;
                                end
                                scpb_pkg::PORT_STATUS:
                                    rdata_next = status_reg;
                                scpb_pkg::PORT_CLR_CMD:
                                    status_next[scpb_pkg::STAT_CMD_BIT] = 1'b0;
                                scpb_pkg::PORT_PAGE_STAT:
                                    status_next[scpb_pkg::STAT_DATA_BIT] = page_reg[0];
                                scpb_pkg::PORT_VOL_STAT:
                                    status_next[scpb_pkg::STAT_CMD_BIT] = vol_reg[0][5];
                                default:
                                    rdata_next = 8'hFF;
                            endcase
                        end
                        scpb_pkg::OP_MEM_RD:
                        begin
                            region_next = map_region;
                            offset_next = map_offset[scpb_pkg::OFFSET_W-1:0];
                            if (cmd.capture)
                            begin
                                dac_next      = 1'b1;
                                chan_next     = ch_sel;
                                sample_next   = cmd.data;
                                volume_next   = vol_sel;
                                smp_next[ch_sel] = cmd.data;
                                // accumulate until the counter saturates
                                if (count_sel != COUNT_MAX)
                                begin
                                    sum_next[ch_sel] = sum_add[scpb_pkg::SUM_W] ? '1
                                                       : sum_add[scpb_pkg::SUM_W-1:0];
                                    count_next[ch_sel] = count_sel + 1'b1;
                                end
                            end
                        end
                        scpb_pkg::OP_MEM_WR:
                        begin
                            region_next = map_region;
                            offset_next = map_offset[scpb_pkg::OFFSET_W-1:0];
                        end
                        scpb_pkg::OP_FLUSH:
                        begin
                            done_next  = 1'b0;
                            last_next  = 1'b0;
                            ch_next    = '0;
                            state_next = S_MUL;
                        end
                        default:
                            last_next = 1'b1;
                    endcase
                end
            end

            S_MUL:
            begin
                rem_next   = scpb_pkg::DIV_W'(prod);
                dsh_next   = scpb_pkg::DIV_W'(den) << scpb_pkg::LEVEL_W;
                step_next  = FIRST_STEP;
                q_next     = '0;
                sat_next   = 1'b0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // first step only tests for a quotient of 16 or more
                if (step_reg == FIRST_STEP)
                begin
                    sat_next = cmp;
                end
                else if (cmp)
                begin
                    rem_next = diff;
                    q_next[step_reg[1:0]] = 1'b1;
                end
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    done_next   = 1'b1;
                    chan_next   = ch_reg;
                    sample_next = smp_sel;
                    volume_next = vol_sel;
                    level_next  = sat_next ? '1 : q_next;
                    last_next   = (ch_reg == LAST_CH);
                    sum_next[ch_reg]   = '0;
                    count_next[ch_reg] = '0;
                    if (ch_reg == LAST_CH)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_latch_reg <= '0;
            h2c_reg       <= '0;
            c2h_reg       <= '0;
            status_reg    <= '0;
            page_reg      <= '0;
            for (int k = 0; k < scpb_pkg::NUM_CH; k++)
            begin
                vol_reg[k]   <= '0;
                smp_reg[k]   <= '0;
                sum_reg[k]   <= '0;
                count_reg[k] <= '0;
            end
            ch_reg     <= '0;
            done       <= 1'b0;
            read_data  <= '0;
            mem_region <= '0;
            mem_offset <= '0;
            dac_valid  <= 1'b0;
            channel    <= '0;
            sample     <= '0;
            volume     <= '0;
            level      <= '0;
            last       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_latch_reg <= cmd_latch_next;
            h2c_reg       <= h2c_next;
            c2h_reg       <= c2h_next;
            status_reg    <= status_next;
            page_reg      <= page_next;
            vol_reg       <= vol_next;
            smp_reg       <= smp_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ch_reg        <= ch_next;
            done       <= done_next;
            read_data  <= rdata_next;
            mem_region <= region_next;
            mem_offset <= offset_next;
            dac_valid  <= dac_next;
            channel    <= chan_next;
            sample     <= sample_next;
            volume     <= volume_next;
            level      <= level_next;
            last       <= last_next;
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        step_reg <= step_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
    end

endmodule

`default_nettype wire
